[src/tfpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfpc_pkg
// Shared widths, event and register codes and the fit microprogram for the
// four point touch calibrator.
// ----------------------------------------------------------------------------
package tfpc_pkg;

    localparam int SPAN_W   = 12;
    localparam int FRAC_W   = 16;
    localparam int SCALE_W  = SPAN_W + FRAC_W;
    localparam int OFFSET_W = 32;
    localparam int DBNC_W   = 16;
    localparam int TIME_W   = 32;
    localparam int CNT_W    = $clog2(SCALE_W);
    localparam int UPC_W    = 3;

    localparam logic [1:0] MODE_TOUCH  = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_CANCEL = 2'd2;

    localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [1:0] CFG_X_SPAN   = 2'd1;
    localparam logic [1:0] CFG_Y_SPAN   = 2'd2;
    localparam logic [1:0] CFG_ORIGIN   = 2'd3;

    localparam logic [DBNC_W-1:0] DEBOUNCE_RESET = 16'd300;
    localparam logic [SPAN_W-1:0] X_SPAN_RESET   = 12'd280;
    localparam logic [SPAN_W-1:0] Y_SPAN_RESET   = 12'd200;
    localparam logic [SPAN_W-1:0] ORIGIN_RESET   = 12'd20;

    localparam logic [2:0] PHASE_IDLE  = 3'd0;
    localparam logic [2:0] PHASE_FIRST = 3'd1;
    localparam logic [2:0] PHASE_LAST  = 3'd4;
    localparam logic [2:0] PHASE_DONE  = 3'd5;

    // micro-operations
    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_MINMAX = 3'd1;
    localparam logic [2:0] OP_SPAN   = 3'd2;
    localparam logic [2:0] OP_DIV    = 3'd3;
    localparam logic [2:0] OP_MUL    = 3'd4;
    localparam logic [2:0] OP_OFFSET = 3'd5;
    localparam logic [2:0] OP_AXIS   = 3'd6;
    localparam logic [2:0] OP_DONE   = 3'd7;

    // sequencing conditions
    localparam logic [1:0] COND_NEXT = 2'd0;
    localparam logic [1:0] COND_LOOP = 2'd1;
    localparam logic [1:0] COND_ZERO = 2'd2;
    localparam logic [1:0] COND_AXIS = 2'd3;

    typedef struct packed {
        logic [2:0]       op;
        logic [1:0]       cond;
        logic [UPC_W-1:0] target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
        ucode_t w;
        case (upc)
            3'd0:    w = '{op: OP_LOAD,   cond: COND_NEXT, target: 3'd0};
            3'd1:    w = '{op: OP_MINMAX, cond: COND_LOOP, target: 3'd1};
            3'd2:    w = '{op: OP_SPAN,   cond: COND_ZERO, target: 3'd4};
            3'd3:    w = '{op: OP_DIV,    cond: COND_LOOP, target: 3'd3};
            3'd4:    w = '{op: OP_MUL,    cond: COND_NEXT, target: 3'd0};
            3'd5:    w = '{op: OP_OFFSET, cond: COND_NEXT, target: 3'd0};
            3'd6:    w = '{op: OP_AXIS,   cond: COND_AXIS, target: 3'd0};
            3'd7:    w = '{op: OP_DONE,   cond: COND_NEXT, target: 3'd0};
            default: w = '{op: OP_DONE,   cond: COND_NEXT, target: 3'd0};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

[src/touch_four_point_calibrator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_four_point_calibrator_unit
// Four point linear touch calibration with debounce, min/max search and
// per-axis Q16 scale and saturated offset.
// ----------------------------------------------------------------------------
// Usage: each slave word is one event (tuser = mode: touch, start, cancel)
// with raw X/Y and a millisecond timestamp; each event yields exactly one
// master word with status in tuser and the coefficients in tdata.
// The cfg channel writes debounce, screen spans and origin; cfg_ready is
// always high and writes are expected only while the block is idle.
// An event that does not finish calibration passes from idle to the
// emit state, which loads the output register and raises m_tvalid once that
// register is free; no new event is taken until the emit state is left.
// The touch that stores the fourth point first runs the fit microprogram:
// per axis 1 load, 3 min/max, 1 span, 28 divide steps, 1 multiply,
// 1 offset and 1 axis step, then 1 finish step, 73 steps in all (the divide
// steps are skipped for an axis whose raw span is zero). The restoring
// divider yields one quotient bit per cycle.
// One event is in work at a time; s_tready is high only when idle. A result
// waits in the output register while the receiver stalls, and the next event
// may be accepted meanwhile; its result waits until that register frees.
// Reset (aresetn low, synchronous) restores default registers, clears the
// stored points, the phase and the last accept time, and drops m_tvalid.
// ----------------------------------------------------------------------------
module touch_four_point_calibrator_unit #(
    parameter int ADC_BITS = 12
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // raw_x, raw_y, now_ms
    input  wire  [((2*ADC_BITS+32+7)/8)*8-1:0] s_tdata,
    // mode
    input  wire  [1:0]                       s_tuser,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // scale_x, offset_x, scale_y, offset_y
    output logic [119:0]                     m_tdata,
    // complete, accepted, phase[2:0], span_error
    output logic [5:0]                       m_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [1:0]                       cfg_index,
    input  wire  [tfpc_pkg::DBNC_W-1:0]      cfg_data
);
    import tfpc_pkg::*;

    localparam int PT_W   = 2 * ADC_BITS;
    localparam int PROD_W = ADC_BITS + SCALE_W;
    localparam int OFF_W  = PROD_W + 2;
    localparam logic signed [OFF_W-1:0] OFF_MAX = {{(OFF_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [OFF_W-1:0] OFF_MIN = {{(OFF_W-31){1'b1}}, 31'b0};

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]          state_reg;
    logic [DBNC_W-1:0]   debounce_reg;
    logic [SPAN_W-1:0]   x_span_reg;
    logic [SPAN_W-1:0]   y_span_reg;
    logic [SPAN_W-1:0]   origin_reg;
    logic [2:0]          phase_reg;
    logic [TIME_W-1:0]   last_time_reg;
    logic [PT_W-1:0]     pts_reg [4];

    logic [UPC_W-1:0]    upc_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                axis_reg;
    logic [ADC_BITS-1:0] lo_reg;
    logic [ADC_BITS-1:0] hi_reg;
    logic [ADC_BITS-1:0] rspan_reg;
    logic [ADC_BITS-1:0] rem_reg;
    logic [SCALE_W-1:0]  dvd_reg;
    logic [SCALE_W-1:0]  quo_reg;
    logic [PROD_W-1:0]   prod_reg;

    logic                res_complete_reg;
    logic                res_accepted_reg;
    logic [2:0]          res_phase_reg;
    logic                res_err_reg;
    logic [SCALE_W-1:0]  res_sx_reg;
    logic [OFFSET_W-1:0] res_ox_reg;
    logic [SCALE_W-1:0]  res_sy_reg;
    logic [OFFSET_W-1:0] res_oy_reg;

    logic                m_tvalid_reg;
    logic [119:0]        m_tdata_reg;
    logic [5:0]          m_tuser_reg;

    logic [1:0]          ev_mode;
    logic [ADC_BITS-1:0] ev_x;
    logic [ADC_BITS-1:0] ev_y;
    logic [TIME_W-1:0]   ev_now;
    logic [TIME_W-1:0]   elapsed;
    logic                debounce_ok;
    logic                s_accept;
    logic                store_pt;
    logic [2:0]          phase_next;

    ucode_t              uw;
    logic [UPC_W-1:0]    upc_next;
    logic [1:0]          pt_idx;
    logic [ADC_BITS-1:0] pt_val;
    logic [ADC_BITS:0]   rem_shift;
    logic [ADC_BITS:0]   rem_diff;
    logic                rem_ge;
    logic [PROD_W-1:0]   prod_calc;
    logic signed [OFF_W-1:0] off_wide;
    logic [OFFSET_W-1:0] off_sat;

    assign ev_mode = s_tuser;
    assign ev_x    = s_tdata[ADC_BITS-1:0];
    assign ev_y    = s_tdata[PT_W-1:ADC_BITS];
    assign ev_now  = s_tdata[PT_W+TIME_W-1:PT_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;

    assign elapsed     = ev_now - last_time_reg;
    assign debounce_ok = (elapsed >= TIME_W'(debounce_reg));
    assign store_pt    = (ev_mode == MODE_TOUCH) && debounce_ok &&
                         (phase_reg >= PHASE_FIRST) && (phase_reg <= PHASE_LAST);

    always_comb begin
        case (ev_mode)
            MODE_START:  phase_next = PHASE_FIRST;
            MODE_CANCEL: phase_next = PHASE_IDLE;
            MODE_TOUCH:  phase_next = store_pt ? phase_reg + 3'd1 : phase_reg;
            default:     phase_next = phase_reg;
        endcase
    end

    // microprogram datapath
    assign uw     = ucode_rom(upc_reg);
    assign pt_idx = 2'd3 - cnt_reg[1:0];
    assign pt_val = axis_reg ? pts_reg[pt_idx][PT_W-1:ADC_BITS]
                             : pts_reg[pt_idx][ADC_BITS-1:0];

    assign rem_shift = {rem_reg, dvd_reg[SCALE_W-1]};
    assign rem_diff  = rem_shift - {1'b0, rspan_reg};
    assign rem_ge    = (rem_shift >= {1'b0, rspan_reg});

    assign prod_calc = PROD_W'(lo_reg) * PROD_W'(quo_reg);
    assign off_wide  = signed'(OFF_W'({origin_reg, {FRAC_W{1'b0}}})) -
                       signed'(OFF_W'(prod_reg));

    always_comb begin
        if (off_wide > OFF_MAX) begin
            off_sat = OFF_MAX[OFFSET_W-1:0];
        end else if (off_wide < OFF_MIN) begin
            off_sat = OFF_MIN[OFFSET_W-1:0];
        end else begin
            off_sat = off_wide[OFFSET_W-1:0];
        end
    end

    always_comb begin
        case (uw.cond)
            COND_NEXT: upc_next = upc_reg + 1'b1;
            COND_LOOP: upc_next = (cnt_reg != '0) ? uw.target : upc_reg + 1'b1;
            COND_ZERO: upc_next = (hi_reg == lo_reg) ? uw.target : upc_reg + 1'b1;
            COND_AXIS: upc_next = !axis_reg ? uw.target : upc_reg + 1'b1;
            default:   upc_next = upc_reg + 1'b1;
        endcase
    end

    // control state, configuration and stored points
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            debounce_reg  <= DEBOUNCE_RESET;
            x_span_reg    <= X_SPAN_RESET;
            y_span_reg    <= Y_SPAN_RESET;
            origin_reg    <= ORIGIN_RESET;
            phase_reg     <= PHASE_IDLE;
            last_time_reg <= '0;
            upc_reg       <= '0;
            axis_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                pts_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DEBOUNCE: debounce_reg <= cfg_data;
                    CFG_X_SPAN:   x_span_reg   <= cfg_data[SPAN_W-1:0];
                    CFG_Y_SPAN:   y_span_reg   <= cfg_data[SPAN_W-1:0];
                    CFG_ORIGIN:   origin_reg   <= cfg_data[SPAN_W-1:0];
                    default:      debounce_reg <= debounce_reg;
                endcase
            end

            if (state_reg == ST_EMIT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        phase_reg <= phase_next;
                        if (ev_mode == MODE_START) begin
                            last_time_reg <= ev_now;
                            for (int i = 0; i < 4; i++) begin
                                pts_reg[i] <= '0;
                            end
                        end else if (ev_mode == MODE_TOUCH && debounce_ok) begin
                            last_time_reg <= ev_now;
                        end
                        if (store_pt) begin
                            pts_reg[2'(phase_reg - 3'd1)] <= {ev_y, ev_x};
                        end
                        upc_reg  <= '0;
                        axis_reg <= 1'b0;
                        state_reg <= (store_pt && phase_reg == PHASE_LAST) ? ST_RUN
                                                                            : ST_EMIT;
                    end
                end
                ST_RUN: begin
                    upc_reg <= upc_next;
                    if (uw.op == OP_AXIS) begin
                        axis_reg <= !axis_reg;
                    end
                    if (uw.op == OP_DONE) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload: fit datapath, result and output word
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_accept) begin
            res_complete_reg <= 1'b0;
            res_accepted_reg <= (ev_mode == MODE_TOUCH) && debounce_ok;
            res_phase_reg    <= phase_next;
            res_err_reg      <= 1'b0;
            res_sx_reg       <= '0;
            res_ox_reg       <= '0;
            res_sy_reg       <= '0;
            res_oy_reg       <= '0;
        end

        if (state_reg == ST_RUN) begin
            case (uw.op)
                OP_LOAD: begin
                    lo_reg  <= axis_reg ? pts_reg[0][PT_W-1:ADC_BITS]
                                        : pts_reg[0][ADC_BITS-1:0];
                    hi_reg  <= axis_reg ? pts_reg[0][PT_W-1:ADC_BITS]
                                        : pts_reg[0][ADC_BITS-1:0];
                    cnt_reg <= CNT_W'(2);
                end
                OP_MINMAX: begin
                    if (pt_val < lo_reg) begin
                        lo_reg <= pt_val;
                    end
                    if (pt_val > hi_reg) begin
                        hi_reg <= pt_val;
                    end
                    if (cnt_reg != '0) begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                OP_SPAN: begin
                    rspan_reg <= hi_reg - lo_reg;
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    dvd_reg   <= {(axis_reg ? y_span_reg : x_span_reg), {FRAC_W{1'b0}}};
                    cnt_reg   <= CNT_W'(SCALE_W - 1);
                    if (hi_reg == lo_reg) begin
                        res_err_reg <= 1'b1;
                    end
                end
                OP_DIV: begin
                    rem_reg <= rem_ge ? rem_diff[ADC_BITS-1:0] : rem_shift[ADC_BITS-1:0];
                    quo_reg <= {quo_reg[SCALE_W-2:0], rem_ge};
                    dvd_reg <= {dvd_reg[SCALE_W-2:0], 1'b0};
                    if (cnt_reg != '0) begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                OP_MUL: begin
                    prod_reg <= prod_calc;
                end
                OP_OFFSET: begin
                    if (axis_reg) begin
                        res_sy_reg <= quo_reg;
                        res_oy_reg <= off_sat;
                    end else begin
                        res_sx_reg <= quo_reg;
                        res_ox_reg <= off_sat;
                    end
                end
                OP_DONE: begin
                    res_complete_reg <= !res_err_reg;
                end
                default: begin
                    prod_reg <= prod_reg;
                end
            endcase
        end

        if (state_reg == ST_EMIT && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {res_oy_reg, res_sy_reg, res_ox_reg, res_sx_reg};
            m_tuser_reg <= {res_err_reg, res_phase_reg, res_accepted_reg, res_complete_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    // an event is taken only once, then the block is busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("event accepted while previous event still in work");

    // a finished fit never reports a span error and always ends in done
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tuser[5] && m_tuser[1] && (m_tuser[4:2] == PHASE_DONE))
        else $error("complete word with inconsistent status");

    // the fit program only runs after the fourth point was stored
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (phase_reg == PHASE_DONE))
        else $error("fit running outside the done phase");

    // a result word is never overwritten while the receiver stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");
`endif

endmodule
`default_nettype wire
